// ----- rtl/anrt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anrt_pkg: shared types and constants for the request tracker
// Word formats, operation and result codes, and the command/status
// bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package anrt_pkg;

  localparam int ID_BITS      = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int RETRY_BITS   = 4;

  localparam logic [RETRY_BITS-1:0] RETRY_RESET = 4'd5;

  // Operation carried by an input word.
  typedef enum logic [1:0] {
    MODE_SEND = 2'd0,
    MODE_CMD  = 2'd1,
    MODE_ACK  = 2'd2,
    MODE_NACK = 2'd3
  } mode_t;

  // Result reported by an output word.
  typedef enum logic [2:0] {
    KIND_TRANSMIT  = 3'd0,
    KIND_NOTED     = 3'd1,
    KIND_DONE      = 3'd2,
    KIND_FAILED    = 3'd3,
    KIND_ACK_MISS  = 3'd4,
    KIND_NACK_MISS = 3'd5,
    KIND_FULL      = 3'd6
  } kind_t;

  typedef struct packed {
    mode_t                   mode;
    logic [ID_BITS-1:0]      msg_id;
    logic [PAYLOAD_BITS-1:0] payload;
  } in_word_t;

  typedef struct packed {
    kind_t                   kind;
    logic [ID_BITS-1:0]      out_id;
    logic [PAYLOAD_BITS-1:0] out_payload;
  } out_word_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CMP  = 2'd1,
    ST_UPD  = 2'd2
  } state_t;

  typedef struct packed {
    logic capture;
    logic compare;
    logic update;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/anrt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anrt_ctrl: sequencing controller for the request tracker
// Steps each accepted word through a compare state and an update state,
// and holds the update while the output register is still occupied.
// ----------------------------------------------------------------------------
module anrt_ctrl
  import anrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (status.out_free) begin
          state_next = in_valid ? ST_CMP : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output decode. A new word may be taken in the same cycle as an update.
  always_comb begin
    in_ready    = 1'b0;
    cmd.compare = 1'b0;
    cmd.update  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
      end
      ST_UPD: begin
        in_ready   = status.out_free;
        cmd.update = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.capture = in_valid && in_ready;
  end

  // A captured word is always compared in the very next cycle.
  a_capture_then_compare: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.compare)
    else $error("capture not followed by compare");

  // The table and output are only updated when the output register can load.
  a_update_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> status.out_free)
    else $error("update issued while output register is occupied");

endmodule

// ----- rtl/anrt_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anrt_dp: request table and result datapath
// Holds the outstanding requests packed in arrival order, compares all
// entries against the captured id in parallel, then applies the update
// (append, remove with compaction, or retry decrement) and loads the result.
// ----------------------------------------------------------------------------
module anrt_dp
  import anrt_pkg::*;
#(
  parameter int TABLE_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  input  in_word_t              in_data,
  input  logic                  cfg_valid,
  input  logic [RETRY_BITS-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data
);

  localparam int D = TABLE_DEPTH;

  // Table storage; valid bits stay packed at the low slots.
  logic [D-1:0]            valid;
  logic [ID_BITS-1:0]      ent_id  [D];
  logic [PAYLOAD_BITS-1:0] ent_pay [D];
  logic [RETRY_BITS-1:0]   ent_ret [D];

  logic [RETRY_BITS-1:0]   retries_cfg;
  in_word_t                req;

  // Compare-stage combinational results.
  logic [D:0]              valid_sh;
  logic [D-1:0]            match;
  logic [D-1:0]            first_oh;
  logic [D-1:0]            ge_mask;
  logic [D-1:0]            free_oh;
  logic [ID_BITS-1:0]      sel_id;
  logic [PAYLOAD_BITS-1:0] sel_pay;
  logic [RETRY_BITS-1:0]   sel_ret;

  // Compare-stage registers.
  logic                    hit;
  logic                    full;
  logic [D-1:0]            first_r;
  logic [D-1:0]            rm_r;
  logic [D-1:0]            free_r;
  logic [ID_BITS-1:0]      m_id;
  logic [PAYLOAD_BITS-1:0] m_pay;
  logic [RETRY_BITS-1:0]   m_ret;

  // Update-stage decisions.
  out_word_t               res;
  logic                    do_write;
  logic                    do_remove;
  logic                    do_dec;

  // Retry count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      retries_cfg <= RETRY_RESET;
    end else if (cfg_valid) begin
      retries_cfg <= cfg_data;
    end
  end

  // Input word capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= in_data;
    end
  end

  // Parallel id compare, oldest-match pick and first-free slot.
  always_comb begin
    valid_sh = {valid, 1'b1};
    for (int i = 0; i < D; i++) begin
      match[i] = valid[i] && (ent_id[i] == req.msg_id);
    end
    first_oh = match & (~match + D'(1));
    ge_mask  = (first_oh == '0) ? '0 : ~(first_oh - D'(1));
    free_oh  = ~valid & valid_sh[D-1:0];
    sel_id   = '0;
    sel_pay  = '0;
    sel_ret  = '0;
    for (int i = 0; i < D; i++) begin
      sel_id  = sel_id  | (ent_id[i]  & {ID_BITS{first_oh[i]}});
      sel_pay = sel_pay | (ent_pay[i] & {PAYLOAD_BITS{first_oh[i]}});
      sel_ret = sel_ret | (ent_ret[i] & {RETRY_BITS{first_oh[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      hit     <= |match;
      full    <= &valid;
      first_r <= first_oh;
      rm_r    <= ge_mask;
      free_r  <= free_oh;
      m_id    <= sel_id;
      m_pay   <= sel_pay;
      m_ret   <= sel_ret;
    end
  end

  // Result and table action for the captured word.
  always_comb begin
    res       = '{kind: KIND_NOTED, out_id: '0, out_payload: '0};
    do_write  = 1'b0;
    do_remove = 1'b0;
    do_dec    = 1'b0;
    case (req.mode)
      MODE_SEND: begin
        if (full) begin
          res.kind = KIND_FULL;
        end else begin
          res.kind        = KIND_TRANSMIT;
          res.out_id      = req.msg_id;
          res.out_payload = req.payload;
          do_write        = 1'b1;
        end
      end
      MODE_CMD: begin
        res.kind = KIND_NOTED;
      end
      MODE_ACK: begin
        if (hit) begin
          res.kind        = KIND_DONE;
          res.out_id      = m_id;
          res.out_payload = req.payload;
          do_remove       = 1'b1;
        end else begin
          res.kind = KIND_ACK_MISS;
        end
      end
      MODE_NACK: begin
        if (!hit) begin
          res.kind = KIND_NACK_MISS;
        end else if (m_ret == '0) begin
          res.kind   = KIND_FAILED;
          res.out_id = m_id;
          do_remove  = 1'b1;
        end else begin
          res.kind        = KIND_TRANSMIT;
          res.out_id      = m_id;
          res.out_payload = m_pay;
          do_dec          = 1'b1;
        end
      end
      default: begin
        res.kind = KIND_NOTED;
      end
    endcase
  end

  // Per-slot table update: shift down on removal, append, or decrement.
  for (genvar i = 0; i < D; i++) begin : g_slot
    if (i < D - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (rst) begin
          valid[i] <= 1'b0;
        end else if (cmd.update) begin
          if (do_remove && rm_r[i]) begin
            valid[i] <= valid[i+1];
          end else if (do_write && free_r[i]) begin
            valid[i] <= 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (cmd.update) begin
          if (do_remove && rm_r[i]) begin
            ent_id[i]  <= ent_id[i+1];
            ent_pay[i] <= ent_pay[i+1];
            ent_ret[i] <= ent_ret[i+1];
          end else if (do_write && free_r[i]) begin
            ent_id[i]  <= req.msg_id;
            ent_pay[i] <= req.payload;
            ent_ret[i] <= retries_cfg;
          end else if (do_dec && first_r[i]) begin
            ent_ret[i] <= ent_ret[i] - RETRY_BITS'(1);
          end
        end
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        if (rst) begin
          valid[i] <= 1'b0;
        end else if (cmd.update) begin
          if (do_remove && rm_r[i]) begin
            valid[i] <= 1'b0;
          end else if (do_write && free_r[i]) begin
            valid[i] <= 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (cmd.update) begin
          if (do_write && free_r[i]) begin
            ent_id[i]  <= req.msg_id;
            ent_pay[i] <= req.payload;
            ent_ret[i] <= retries_cfg;
          end else if (do_dec && first_r[i]) begin
            ent_ret[i] <= ent_ret[i] - RETRY_BITS'(1);
          end
        end
      end
    end
  end

  // Output register; it frees up when the word is taken downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_data <= res;
    end
  end

  assign status.out_free = !out_valid || out_ready;

  // Occupied slots never have a free slot below them.
  a_table_packed: assert property (@(posedge clk) disable iff (rst)
    (valid & ~valid_sh[D-1:0]) == '0)
    else $error("request table lost its packed order");

  // The table occupancy only changes on an update cycle.
  a_valid_only_on_update: assert property (@(posedge clk) disable iff (rst)
    !cmd.update |=> $stable(valid))
    else $error("table valid bits changed outside an update");

endmodule

// ----- rtl/ack_nack_retry_tracker_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ack_nack_retry_tracker_unit: outstanding request table with retry
// Each taken word is registered, checked against the table in the compare
// state and applied in the update state, which loads its result word. A new
// word is taken only when idle or with an update, which an output stall holds.
// Reset clears every table slot, empties the output register and sets the
// retry count register to 5. The table needs no clearing pass.
// ----------------------------------------------------------------------------
module ack_nack_retry_tracker_unit
  import anrt_pkg::*;
#(
  parameter int TABLE_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [RETRY_BITS-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The retry count register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  // Sequencing controller.
  anrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Table and result datapath.
  anrt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the outstanding request tracker
// Drives request, command, ack and nack words through valid/ready, keeps a
// shadow of the request table to predict every result word, and checks the
// results in order. It covers a directed table, then random traffic under
// several retry count settings, random stalls on both sides, and a long
// output hold-off that backs the tracker up.
// ----------------------------------------------------------------------------
module tb
  import anrt_pkg::*;
();

  localparam int DEPTH          = 8;
  localparam int IDLE_PCT       = 38;
  localparam int SINK_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 6;
  localparam int LIMIT_NS       = 500_000;
  localparam int DIR_ROWS       = 24;

  // One row of the directed table: either a retry count write or a word,
  // with an optional hand-written expected result.
  typedef struct packed {
    logic                  set_cfg;
    logic [RETRY_BITS-1:0] cfg_val;
    in_word_t              word;
    logic                  typed;
    out_word_t             exp;
  } step_t;

  localparam step_t DIRECTED_STEPS [DIR_ROWS] = '{
    '{1'b0, 4'd0, '{MODE_NACK, 16'h1234, 32'h0000_0000}, 1'b1,
      '{KIND_NACK_MISS, 16'h0000, 32'h0000_0000}},
    '{1'b0, 4'd0, '{MODE_ACK, 16'hFFFF, 32'h0000_0000}, 1'b1,
      '{KIND_ACK_MISS, 16'h0000, 32'h0000_0000}},
    '{1'b0, 4'd0, '{MODE_CMD, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1,
      '{KIND_NOTED, 16'h0000, 32'h0000_0000}},
    '{1'b0, 4'd0, '{MODE_SEND, 16'h0000, 32'h0000_0000}, 1'b1,
      '{KIND_TRANSMIT, 16'h0000, 32'h0000_0000}},
    '{1'b0, 4'd0, '{MODE_SEND, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1,
      '{KIND_TRANSMIT, 16'hFFFF, 32'hFFFF_FFFF}},
    '{1'b0, 4'd0, '{MODE_SEND, 16'h00AA, 32'h1111_1111}, 1'b1,
      '{KIND_TRANSMIT, 16'h00AA, 32'h1111_1111}},
    '{1'b0, 4'd0, '{MODE_SEND, 16'h00AA, 32'h2222_2222}, 1'b1,
      '{KIND_TRANSMIT, 16'h00AA, 32'h2222_2222}},
    '{1'b0, 4'd0, '{MODE_NACK, 16'h00AA, 32'hDEAD_BEEF}, 1'b0, '0},
    '{1'b0, 4'd0, '{MODE_ACK, 16'h00AA, 32'hCAFE_F00D}, 1'b0, '0},
    '{1'b0, 4'd0, '{MODE_NACK, 16'h00AA, 32'h0000_0000}, 1'b0, '0},
    '{1'b0, 4'd0, '{MODE_SEND, 16'h0001, 32'h0101_0101}, 1'b0, '0},
    '{1'b0, 4'd0, '{MODE_SEND, 16'h0002, 32'h0202_0202}, 1'b0, '0},
    '{1'b0, 4'd0, '{MODE_SEND, 16'h0003, 32'h0303_0303}, 1'b0, '0},
    '{1'b0, 4'd0, '{MODE_SEND, 16'h0004, 32'h0404_0404}, 1'b0, '0},
    '{1'b0, 4'd0, '{MODE_SEND, 16'h0005, 32'h0505_0505}, 1'b0, '0},
    '{1'b0, 4'd0, '{MODE_SEND, 16'h7777, 32'h89AB_CDEF}, 1'b1,
      '{KIND_FULL, 16'h0000, 32'h0000_0000}},
    '{1'b0, 4'd0, '{MODE_ACK, 16'h0000, 32'h1234_5678}, 1'b0, '0},
    '{1'b1, 4'd0, '0, 1'b0, '0},
    '{1'b0, 4'd0, '{MODE_SEND, 16'h0BEE, 32'h55AA_55AA}, 1'b0, '0},
    '{1'b0, 4'd0, '{MODE_NACK, 16'h0BEE, 32'h0000_0000}, 1'b1,
      '{KIND_FAILED, 16'h0BEE, 32'h0000_0000}},
    '{1'b1, 4'd15, '0, 1'b0, '0},
    '{1'b0, 4'd0, '{MODE_SEND, 16'h0C0C, 32'hA5A5_A5A5}, 1'b0, '0},
    '{1'b0, 4'd0, '{MODE_NACK, 16'h0C0C, 32'h0000_0000}, 1'b0, '0},
    '{1'b0, 4'd0, '{MODE_ACK, 16'h0C0C, 32'hFFFF_FFFF}, 1'b0, '0}
  };

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_word_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [RETRY_BITS-1:0] cfg_data;

  // Shadow of the request table, oldest entry at slot 0.
  logic                    pend_valid   [DEPTH];
  logic [ID_BITS-1:0]      pend_id      [DEPTH];
  logic [PAYLOAD_BITS-1:0] pend_payload [DEPTH];
  logic [RETRY_BITS-1:0]   pend_retries [DEPTH];
  logic [RETRY_BITS-1:0]   retry_setting;

  out_word_t awaited_words [$];
  int        mismatch_count;
  logic      steady_flow;
  logic      hold_req;

  ack_nack_retry_tracker_unit #(
    .TABLE_DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Number of live entries; the table stays packed at the low slots.
  function automatic int live_entries();
    int n;
    n = 0;
    for (int i = 0; i < DEPTH; i++) begin
      if (pend_valid[i]) n++;
    end
    return n;
  endfunction

  // Remove one entry and slide the younger ones down.
  function automatic void drop_entry(input int slot);
    for (int i = slot; i + 1 < DEPTH; i++) begin
      pend_valid[i]   = pend_valid[i + 1];
      pend_id[i]      = pend_id[i + 1];
      pend_payload[i] = pend_payload[i + 1];
      pend_retries[i] = pend_retries[i + 1];
    end
    pend_valid[DEPTH - 1] = 1'b0;
  endfunction

  // Apply one accepted word to the shadow table and return its result word.
  function automatic out_word_t tracker_response(input in_word_t w);
    out_word_t r;
    int        slot;
    r    = '0;
    slot = -1;
    case (w.mode)
      MODE_SEND: begin
        slot = live_entries();
        if (slot >= DEPTH) begin
          r.kind = KIND_FULL;
        end else begin
          pend_valid[slot]   = 1'b1;
          pend_id[slot]      = w.msg_id;
          pend_payload[slot] = w.payload;
          pend_retries[slot] = retry_setting;
          r = '{KIND_TRANSMIT, w.msg_id, w.payload};
        end
      end
      MODE_CMD: begin
        r.kind = KIND_NOTED;
      end
      default: begin
        for (int i = DEPTH - 1; i >= 0; i--) begin
          if (pend_valid[i] && pend_id[i] == w.msg_id) slot = i;
        end
        if (slot < 0) begin
          r.kind = (w.mode == MODE_ACK) ? KIND_ACK_MISS : KIND_NACK_MISS;
        end else if (w.mode == MODE_ACK) begin
          r = '{KIND_DONE, pend_id[slot], w.payload};
          drop_entry(slot);
        end else if (pend_retries[slot] == '0) begin
          r = '{KIND_FAILED, pend_id[slot], '0};
          drop_entry(slot);
        end else begin
          r = '{KIND_TRANSMIT, pend_id[slot], pend_payload[slot]};
          pend_retries[slot] = pend_retries[slot] - 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // Random word; acks and nacks mostly hit live ids, sends reuse a small id
  // pool so that duplicate ids are common.
  function automatic in_word_t random_word(input int send_pct);
    in_word_t w;
    int       pick;
    int       filled;
    pick      = $urandom_range(99);
    filled    = live_entries();
    w.payload = $urandom();
    if (pick < send_pct) begin
      w.mode   = MODE_SEND;
      w.msg_id = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(15));
    end else if (pick < send_pct + 5) begin
      w.mode   = MODE_CMD;
      w.msg_id = 16'($urandom());
    end else begin
      w.mode = ($urandom_range(1) == 1) ? MODE_ACK : MODE_NACK;
      if (filled > 0 && $urandom_range(9) < 8) begin
        w.msg_id = pend_id[$urandom_range(filled - 1)];
      end else begin
        w.msg_id = 16'($urandom());
      end
    end
    return w;
  endfunction

  // Offer one word, wait for it to be taken, and queue its expected result.
  task automatic offer_word(input in_word_t w, input logic typed, input out_word_t hand_exp);
    out_word_t predicted;
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (!in_ready);
    predicted = tracker_response(w);
    if (typed) predicted = hand_exp;
    awaited_words = {awaited_words, predicted};
  endtask

  // Stop offering and wait until every expected result word has come out.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_words.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the retry count register while the tracker is idle.
  task automatic load_retry_count(input logic [RETRY_BITS-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    retry_setting = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_traffic(input int count, input int send_pct);
    repeat (count) offer_word(random_word(send_pct), 1'b0, '0);
  endtask

  // Result side: random stalls, a steady stretch, and one long hold-off.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_ready = 1'b0;
        repeat (SINK_HOLD - 1) @(negedge clk);
      end else begin
        out_ready = steady_flow || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compare every taken result word with the oldest expectation.
  always @(posedge clk) begin
    out_word_t exp;
    if (!rst && out_valid && out_ready) begin
      if (awaited_words.size() == 0) begin
        $error("unexpected result word: kind %0d id %h payload %h",
               out_data.kind, out_data.out_id, out_data.out_payload);
        mismatch_count++;
      end else begin
        exp = awaited_words.pop_front();
        if (out_data.kind !== exp.kind) begin
          $error("kind: expected %0d, actual %0d", exp.kind, out_data.kind);
          mismatch_count++;
        end
        if (out_data.out_id !== exp.out_id) begin
          $error("out_id: expected %h, actual %h", exp.out_id, out_data.out_id);
          mismatch_count++;
        end
        if (out_data.out_payload !== exp.out_payload) begin
          $error("out_payload: expected %h, actual %h", exp.out_payload,
                 out_data.out_payload);
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    steady_flow    = 1'b0;
    hold_req       = 1'b0;
    mismatch_count = 0;
    retry_setting  = RETRY_RESET;
    for (int i = 0; i < DEPTH; i++) begin
      pend_valid[i]   = 1'b0;
      pend_id[i]      = '0;
      pend_payload[i] = '0;
      pend_retries[i] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED_STEPS[i].set_cfg) begin
        load_retry_count(DIRECTED_STEPS[i].cfg_val);
      end else begin
        offer_word(DIRECTED_STEPS[i].word, DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].exp);
      end
    end

    // Random traffic at the largest retry count.
    random_traffic(400, 40);

    // No retries, and no stalls on either side.
    load_retry_count(4'd0);
    steady_flow = 1'b1;
    random_traffic(300, 45);
    steady_flow = 1'b0;

    // Output held off for a long stretch while words keep coming.
    load_retry_count(4'd15);
    hold_req = 1'b1;
    random_traffic(400, 55);

    // A mid-range count, with a pause until all results are out.
    load_retry_count(4'($urandom_range(14, 1)));
    random_traffic(200, 40);
    drain_results();
    random_traffic(200, 40);

    // One retry per request.
    load_retry_count(4'd1);
    random_traffic(500, 35);

    drain_results();
    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #(LIMIT_NS);
    $display("tb: errors");
    $finish;
  end

endmodule

// ----- ack_nack_retry_tracker_unit.f -----
rtl/anrt_pkg.sv
rtl/anrt_ctrl.sv
rtl/anrt_dp.sv
rtl/ack_nack_retry_tracker_unit.sv
sim/tb.sv
